@@ rtl/spg_pkg.sv @@
package spg_pkg;

	// Field and register widths.
	localparam int unsigned RATE_W   = 32;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned TICK_W   = 32;
	localparam int unsigned ACC_W    = 33;
	localparam int unsigned HOLDMS_W = 16;
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	// Stream payload widths, padded to whole bytes, and the internal result width.
	localparam int unsigned IN_DATA_W  = 72;
	localparam int unsigned OUT_DATA_W = 8;
	localparam int unsigned RES_W      = 4;

	// Hold time arithmetic: ceil(hold_ms * tick_hz / 1000), split as
	// hold_ms * (tick_hz / 1000) + ceil(hold_ms * (tick_hz % 1000) / 1000).
	// Both divisions by 1000 are a multiplication by a rounded-up reciprocal,
	// exact for any 32-bit dividend.
	localparam int unsigned MS_PER_S     = 1000;
	localparam int unsigned ROUND_UP     = MS_PER_S - 1;
	localparam int unsigned RECIP_W      = 29;
	localparam int unsigned RECIP_SHIFT  = 38;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 29'h1062_4DD3;
	localparam int unsigned RECIP_PROD_W = TICK_W + RECIP_W;
	localparam int unsigned QUO_W        = RECIP_PROD_W - RECIP_SHIFT;
	localparam int unsigned REM_W        = 10;
	localparam int unsigned WHOLE_W      = HOLDMS_W + QUO_W;
	localparam int unsigned PART_W       = 26;
	localparam int unsigned FRAC_W       = HOLDMS_W;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK = 2'd0,
		ACT_MOVE = 2'd1,
		ACT_STOP = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICK_HZ      = 2'd0,
		CFG_HOLD_ON_STOP = 2'd1,
		CFG_HOLD_MS      = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		CALC_IDLE = 3'd0,
		CALC_QUO  = 3'd1,
		CALC_REM  = 3'd2,
		CALC_PART = 3'd3,
		CALC_FRAC = 3'd4,
		CALC_SUM  = 3'd5
	} calc_state_t;

endpackage

@@ rtl/stepper_pulse_generator_unit.sv @@
// Step/direction/enable generator with a phase accumulator, one result per input transfer.
// A result is registered in the output register, or in the skid stage if m_tready stalls it.
// One transfer per cycle unless s_tready drops (hold recompute busy, or skid stage full).
// A configuration write recomputes the hold length with reciprocal multiplications by 1/1000;
// s_tready stays low meanwhile (quotient, remainder, part, fraction, sum).
// arst_n resets all motion state (direction to cw), the output register and the skid stage.
module stepper_pulse_generator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [spg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// Slave side: commands and ticks.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata, low bit up: direction_cw[0], step_rate_hz[32:1], step_count[64:33], zeros.
	input  logic [spg_pkg::IN_DATA_W-1:0]       s_tdata,
	// s_tuser: action[1:0].
	input  logic [spg_pkg::ACTION_W-1:0]        s_tuser,
	// Master side: output levels after each item.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata, low bit up: step_out[0], dir_out[1], enable_out[2], is_running[3], zeros.
	output logic [spg_pkg::OUT_DATA_W-1:0]      m_tdata
);

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [spg_pkg::TICK_W-1:0]   tick_hz_q;
	logic                         hold_on_stop_q;
	logic [spg_pkg::HOLDMS_W-1:0] hold_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_hz_q      <= '0;
			hold_on_stop_q <= 1'b1;
			hold_ms_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spg_pkg::CFG_TICK_HZ:      tick_hz_q      <= cfg_wdata[spg_pkg::TICK_W-1:0];
				spg_pkg::CFG_HOLD_ON_STOP: hold_on_stop_q <= cfg_wdata[0];
				spg_pkg::CFG_HOLD_MS:      hold_ms_q      <= cfg_wdata[spg_pkg::HOLDMS_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Hold length sequencer. Every configuration write restarts it, so the
	// precomputed hold count always matches the current registers before
	// the next item is accepted.
	// ------------------------------------------------------------------
	spg_pkg::calc_state_t calc_state_q, calc_state_d;
	logic [spg_pkg::QUO_W-1:0]     quo_q;
	logic [spg_pkg::REM_W-1:0]     rem_q;
	logic [spg_pkg::WHOLE_W-1:0]   whole_q;
	logic [spg_pkg::PART_W-1:0]    part_q;
	logic [spg_pkg::FRAC_W-1:0]    frac_q;
	logic [spg_pkg::TICK_W-1:0]    hold_ticks_q;
	logic                          calc_busy;
	logic                          load_quo, load_rem, load_part, load_frac, load_hold;

	always_comb begin
		calc_state_d = calc_state_q;
		if (cfg_we) begin
			calc_state_d = spg_pkg::CALC_QUO;
		end else begin
			unique case (calc_state_q)
				spg_pkg::CALC_IDLE: calc_state_d = spg_pkg::CALC_IDLE;
				spg_pkg::CALC_QUO:  calc_state_d = spg_pkg::CALC_REM;
				spg_pkg::CALC_REM:  calc_state_d = spg_pkg::CALC_PART;
				spg_pkg::CALC_PART: calc_state_d = spg_pkg::CALC_FRAC;
				spg_pkg::CALC_FRAC: calc_state_d = spg_pkg::CALC_SUM;
				spg_pkg::CALC_SUM:  calc_state_d = spg_pkg::CALC_IDLE;
				default:            calc_state_d = spg_pkg::CALC_IDLE;
			endcase
		end
	end

	always_comb begin
		load_quo  = 1'b0;
		load_rem  = 1'b0;
		load_part = 1'b0;
		load_frac = 1'b0;
		load_hold = 1'b0;
		calc_busy = 1'b1;
		unique case (calc_state_q)
			spg_pkg::CALC_IDLE: calc_busy = 1'b0;
			spg_pkg::CALC_QUO:  load_quo  = 1'b1;
			spg_pkg::CALC_REM:  load_rem  = 1'b1;
			spg_pkg::CALC_PART: load_part = 1'b1;
			spg_pkg::CALC_FRAC: load_frac = 1'b1;
			spg_pkg::CALC_SUM:  load_hold = 1'b1;
			default: calc_busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calc_state_q <= spg_pkg::CALC_IDLE;
		end else begin
			calc_state_q <= calc_state_d;
		end
	end

	// The tick rate splits into whole thousands and a remainder below 1000.
	// The whole part times hold_ms needs no rounding; only the remainder part
	// is rounded up. One reciprocal multiplier serves both divisions by 1000.
	logic [spg_pkg::TICK_W-1:0]       recip_arg;
	logic [spg_pkg::RECIP_PROD_W-1:0] recip_prod;
	logic [spg_pkg::QUO_W-1:0]        recip_quo;
	logic [spg_pkg::REM_W-1:0]        rem_calc;
	logic [spg_pkg::WHOLE_W:0]        hold_sum;
	logic [spg_pkg::TICK_W-1:0]       hold_sat;

	assign recip_arg  = load_quo ? tick_hz_q : spg_pkg::TICK_W'(part_q);
	assign recip_prod = spg_pkg::RECIP_PROD_W'(recip_arg)
	                  * spg_pkg::RECIP_PROD_W'(spg_pkg::RECIP_1000);
	assign recip_quo  = recip_prod[spg_pkg::RECIP_PROD_W-1:spg_pkg::RECIP_SHIFT];
	// The remainder is below 1000, so the low bits of the difference are enough.
	assign rem_calc   = tick_hz_q[spg_pkg::REM_W-1:0]
	                  - quo_q[spg_pkg::REM_W-1:0] * spg_pkg::REM_W'(spg_pkg::MS_PER_S);
	assign hold_sum   = {1'b0, whole_q} + (spg_pkg::WHOLE_W+1)'(frac_q);

	always_comb begin
		if (|hold_sum[spg_pkg::WHOLE_W:spg_pkg::TICK_W]) begin
			hold_sat = '1;
		end else if (hold_sum[spg_pkg::TICK_W-1:0] == '0) begin
			hold_sat = spg_pkg::TICK_W'(1);
		end else begin
			hold_sat = hold_sum[spg_pkg::TICK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= '0;
		end else if (load_hold) begin
			hold_ticks_q <= hold_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (load_quo) begin
			quo_q <= recip_quo;
		end
		if (load_rem) begin
			rem_q   <= rem_calc;
			whole_q <= spg_pkg::WHOLE_W'(hold_ms_q) * spg_pkg::WHOLE_W'(quo_q);
		end
		if (load_part) begin
			part_q <= spg_pkg::PART_W'(hold_ms_q) * spg_pkg::PART_W'(rem_q)
			        + spg_pkg::PART_W'(spg_pkg::ROUND_UP);
		end
		if (load_frac) begin
			frac_q <= recip_quo[spg_pkg::FRAC_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Input fields.
	// ------------------------------------------------------------------
	logic [spg_pkg::ACTION_W-1:0] in_action;
	logic                         in_dir_cw;
	logic [spg_pkg::RATE_W-1:0]   in_rate;
	logic [spg_pkg::COUNT_W-1:0]  in_count;

	assign in_action = s_tuser;
	assign in_dir_cw = s_tdata[0];
	assign in_rate   = s_tdata[spg_pkg::RATE_W:1];
	assign in_count  = s_tdata[spg_pkg::RATE_W+spg_pkg::COUNT_W:spg_pkg::RATE_W+1];

	// ------------------------------------------------------------------
	// Motion state and its next value for the item being transferred.
	// ------------------------------------------------------------------
	logic                          running_q, running_d;
	logic [spg_pkg::RATE_W-1:0]    rate_q, rate_d;
	logic [spg_pkg::ACC_W-1:0]     acc_q, acc_d;
	logic [spg_pkg::COUNT_W-1:0]   target_q, target_d;
	logic [spg_pkg::COUNT_W-1:0]   emitted_q, emitted_d;
	logic                          pulse_q, pulse_d;
	logic                          stop_after_q, stop_after_d;
	logic                          dir_q, dir_d;
	logic [spg_pkg::TICK_W-1:0]    hold_left_q, hold_left_d;
	logic                          enable_q, enable_d;

	logic [spg_pkg::ACC_W-1:0]     tick_ext;
	logic [spg_pkg::ACC_W-1:0]     acc_sum;
	logic                          acc_ge;
	logic [spg_pkg::COUNT_W-1:0]   emitted_inc;
	logic [spg_pkg::RATE_W-1:0]    rate_clamped;
	logic                          stop_now;

	assign tick_ext     = {1'b0, tick_hz_q};
	assign acc_sum      = acc_q + {1'b0, rate_q};
	assign acc_ge       = (acc_sum >= tick_ext);
	assign emitted_inc  = emitted_q + spg_pkg::COUNT_W'(1);
	assign rate_clamped = (in_rate > tick_hz_q) ? tick_hz_q : in_rate;

	always_comb begin
		running_d    = running_q;
		rate_d       = rate_q;
		acc_d        = acc_q;
		target_d     = target_q;
		emitted_d    = emitted_q;
		pulse_d      = pulse_q;
		stop_after_d = stop_after_q;
		dir_d        = dir_q;
		hold_left_d  = hold_left_q;
		enable_d     = enable_q;
		stop_now     = 1'b0;

		unique case (in_action)
			spg_pkg::ACT_TICK: begin
				if (!running_q) begin
					// Idle tick: count down an active hold.
					if (hold_left_q != '0) begin
						hold_left_d = hold_left_q - spg_pkg::TICK_W'(1);
						if (hold_left_q == spg_pkg::TICK_W'(1)) begin
							enable_d = 1'b0;
						end
					end
				end else if (pulse_q) begin
					// Trailing edge of a step pulse; the final one ends the move.
					pulse_d = 1'b0;
					if (stop_after_q) begin
						stop_now = 1'b1;
					end
				end else begin
					acc_d = acc_sum;
					if (acc_ge) begin
						acc_d   = acc_sum - tick_ext;
						pulse_d = 1'b1;
						if (target_q != '0) begin
							emitted_d = emitted_inc;
							if (emitted_inc >= target_q) begin
								stop_after_d = 1'b1;
							end
						end
					end
				end
			end
			spg_pkg::ACT_MOVE: begin
				if ((in_rate == '0) || (tick_hz_q == '0)) begin
					stop_now = 1'b1;
				end else begin
					dir_d        = in_dir_cw;
					rate_d       = rate_clamped;
					running_d    = 1'b1;
					acc_d        = '0;
					target_d     = in_count;
					emitted_d    = '0;
					pulse_d      = 1'b0;
					stop_after_d = 1'b0;
					hold_left_d  = '0;
					enable_d     = 1'b1;
				end
			end
			spg_pkg::ACT_STOP: stop_now = 1'b1;
			default: ;
		endcase

		if (stop_now) begin
			running_d    = 1'b0;
			rate_d       = '0;
			acc_d        = '0;
			target_d     = '0;
			emitted_d    = '0;
			pulse_d      = 1'b0;
			stop_after_d = 1'b0;
			hold_left_d  = '0;
			priority if (!hold_on_stop_q) begin
				enable_d = 1'b0;
			end else if (hold_ms_q == '0) begin
				enable_d = 1'b1;
			end else if (tick_hz_q == '0) begin
				enable_d = 1'b0;
			end else begin
				enable_d    = 1'b1;
				hold_left_d = hold_ticks_q;
			end
		end
	end

	// ------------------------------------------------------------------
	// Handshake. The skid stage lets a transfer complete while the output
	// register still waits on m_tready.
	// ------------------------------------------------------------------
	logic                        out_valid_q, skid_valid_q;
	logic [spg_pkg::RES_W-1:0]   out_q, skid_q;
	logic [spg_pkg::RES_W-1:0]   result;
	logic                        accept;

	assign s_tready = !calc_busy && !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign result   = {running_d, enable_d, dir_d, pulse_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			rate_q       <= '0;
			acc_q        <= '0;
			target_q     <= '0;
			emitted_q    <= '0;
			pulse_q      <= 1'b0;
			stop_after_q <= 1'b0;
			dir_q        <= 1'b1;
			hold_left_q  <= '0;
			enable_q     <= 1'b0;
		end else if (accept) begin
			running_q    <= running_d;
			rate_q       <= rate_d;
			acc_q        <= acc_d;
			target_q     <= target_d;
			emitted_q    <= emitted_d;
			pulse_q      <= pulse_d;
			stop_after_q <= stop_after_d;
			dir_q        <= dir_d;
			hold_left_q  <= hold_left_d;
			enable_q     <= enable_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else if (m_tready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q        <= skid_q;
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
				if (accept) begin
					out_q <= result;
				end
			end
		end else if (accept) begin
			skid_q       <= result;
			skid_valid_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(spg_pkg::OUT_DATA_W - spg_pkg::RES_W){1'b0}}, out_q};

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid stage holds a result while the output register is empty");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		calc_busy |-> !s_tready)
		else $error("transfer possible while the hold length is being recomputed");

	a_pulse_when_running: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_q |-> running_q)
		else $error("step pulse high without a move in progress");

	a_enabled_when_running: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> enable_q)
		else $error("driver disabled during a move");

	a_stop_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_action == spg_pkg::ACT_STOP)) |=> !running_q)
		else $error("stop command did not end the move");

endmodule

@@ bench/spg_levels_check.sv @@
module spg_levels_check
	import spg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// s_tdata, low bit up: direction_cw[0], step_rate_hz[32:1], step_count[64:33], zeros.
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: action[1:0].
	input  logic [ACTION_W-1:0]   s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata, low bit up: step_out[0], dir_out[1], enable_out[2], is_running[3], zeros.
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int unsigned           mismatch_cnt,
	output int unsigned           pending_cnt,
	output int unsigned           checked_cnt,
	output int unsigned           pulse_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] HOLD_ROUND = 64'd999;
	localparam logic [63:0] HOLD_DIV   = 64'd1000;
	localparam logic [63:0] HOLD_SAT   = 64'h0000_0000_FFFF_FFFF;

	// Output levels in the same bit order as m_tdata[3:0].
	typedef struct packed {
		logic running;
		logic enable;
		logic dir;
		logic step;
	} levels_t;

	logic [TICK_W-1:0]   tick_hz;
	logic                hold_on;
	logic [HOLDMS_W-1:0] hold_ms;

	logic               moving;
	logic [RATE_W-1:0]  rate;
	logic [ACC_W-1:0]   acc;
	logic [COUNT_W-1:0] target;
	logic [COUNT_W-1:0] emitted;
	logic               pulse;
	logic               last_pulse;
	logic               dir_cw;
	logic [31:0]        hold_left;
	logic               drive_en;

	levels_t     expected_levels[$];
	int unsigned n_bad;
	int unsigned n_checked;
	int unsigned n_pulses;

	function automatic void power_on();
		tick_hz    = '0;
		hold_on    = 1'b1;
		hold_ms    = '0;
		moving     = 1'b0;
		rate       = '0;
		acc        = '0;
		target     = '0;
		emitted    = '0;
		pulse      = 1'b0;
		last_pulse = 1'b0;
		dir_cw     = 1'b1;
		hold_left  = '0;
		drive_en   = 1'b0;
	endfunction

	// Stop the motion and decide how long the driver stays enabled.
	function automatic void halt_motion();
		logic [63:0] ticks;
		moving     = 1'b0;
		rate       = '0;
		acc        = '0;
		target     = '0;
		emitted    = '0;
		pulse      = 1'b0;
		last_pulse = 1'b0;
		hold_left  = '0;
		if (!hold_on) begin
			drive_en = 1'b0;
		end else if (hold_ms == '0) begin
			drive_en = 1'b1;
		end else if (tick_hz == '0) begin
			drive_en = 1'b0;
		end else begin
			ticks = (64'(hold_ms) * 64'(tick_hz) + HOLD_ROUND) / HOLD_DIV;
			if (ticks > HOLD_SAT) begin
				ticks = HOLD_SAT;
			end
			drive_en  = 1'b1;
			hold_left = ticks[31:0];
		end
	endfunction

	function automatic void tick_motion();
		if (!moving) begin
			if (hold_left != '0) begin
				hold_left--;
				if (hold_left == '0) begin
					drive_en = 1'b0;
				end
			end
			return;
		end
		// The tick after a pulse only lowers it; the accumulator rests.
		if (pulse) begin
			pulse = 1'b0;
			if (last_pulse) begin
				halt_motion();
			end
			return;
		end
		acc = acc + ACC_W'(rate);
		if (acc >= ACC_W'(tick_hz)) begin
			acc   = acc - ACC_W'(tick_hz);
			pulse = 1'b1;
			if (target != '0) begin
				emitted++;
				if (emitted >= target) begin
					last_pulse = 1'b1;
				end
			end
		end
	endfunction

	function automatic void start_move(logic cw, logic [RATE_W-1:0] req_rate,
			logic [COUNT_W-1:0] count);
		if (req_rate == '0 || tick_hz == '0) begin
			halt_motion();
			return;
		end
		dir_cw     = cw;
		rate       = (req_rate > tick_hz) ? tick_hz : req_rate;
		moving     = 1'b1;
		acc        = '0;
		target     = count;
		emitted    = '0;
		pulse      = 1'b0;
		last_pulse = 1'b0;
		hold_left  = '0;
		drive_en   = 1'b1;
	endfunction

	function automatic void check_level(string field, logic want, logic got);
		if (want !== got) begin
			$error("result %0d: %s mismatch: expected %0d, got %0d",
				n_checked, field, want, got);
			n_bad++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		levels_t got;
		levels_t want;
		if (!arst_n) begin
			power_on();
			expected_levels.delete();
			n_bad     = 0;
			n_checked = 0;
			n_pulses  = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TICK_HZ:      tick_hz = cfg_wdata[TICK_W-1:0];
					CFG_HOLD_ON_STOP: hold_on = cfg_wdata[0];
					CFG_HOLD_MS:      hold_ms = cfg_wdata[HOLDMS_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					ACT_TICK: tick_motion();
					ACT_MOVE: start_move(s_tdata[0], s_tdata[32:1], s_tdata[64:33]);
					ACT_STOP: halt_motion();
					default: ;
				endcase
				expected_levels.push_back({moving, drive_en, dir_cw, pulse});
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[RES_W-1:0];
				if (expected_levels.size() == 0) begin
					$error("result 0x%0h arrived with no command waiting", got);
					n_bad++;
				end else begin
					want = expected_levels.pop_front();
					check_level("step_out", want.step, got.step);
					check_level("dir_out", want.dir, got.dir);
					check_level("enable_out", want.enable, got.enable);
					check_level("is_running", want.running, got.running);
					n_checked++;
					if (want.step) begin
						n_pulses++;
					end
				end
			end
		end
		mismatch_cnt <= n_bad;
		pending_cnt  <= expected_levels.size();
		checked_cnt  <= n_checked;
		pulse_cnt    <= n_pulses;
	end

endmodule

@@ bench/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spg_pkg::*;

	localparam int unsigned CLK_HALF        = 5;
	localparam int unsigned RESET_CYCLES    = 3;
	localparam int unsigned TIMEOUT_NS      = 5_000_000;
	// Long enough for the result register and the skid stage to fill and stall the input.
	localparam int unsigned HOLDOFF_CYCLES  = 200;
	// Bound on the wait for outstanding results at a phase end.
	localparam int unsigned DRAIN_LIMIT     = 2000;
	// Settling margin after all expected results have been checked.
	localparam int unsigned SETTLE_CYCLES   = 4;
	localparam int unsigned RANDOM_PHASES   = 7;
	localparam int unsigned ITEMS_PER_PHASE = 75;

	// Codes outside the package lists: an action the block ignores and a
	// register index that does not exist.
	localparam logic [ACTION_W-1:0]  ACT_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE   = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [ACTION_W-1:0]   s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	int unsigned mismatch_cnt;
	int unsigned pending_cnt;
	int unsigned checked_cnt;
	int unsigned pulse_cnt;

	// Pacing controls for the sender and the receiver, and the drain failure flag.
	bit tx_eager;
	bit rx_eager;
	bit holdoff_req;
	bit drain_stuck;

	// Current tick rate, kept only to shape the random step rates.
	logic [TICK_W-1:0] tick_setting;

	int unsigned n_tick;
	int unsigned n_move;
	int unsigned n_stop;
	int unsigned n_unused;
	int unsigned n_writes;

	stepper_pulse_generator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// The checker sees every transfer on both channels and every register write.
	spg_levels_check levels_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.mismatch_cnt (mismatch_cnt),
		.pending_cnt  (pending_cnt),
		.checked_cnt  (checked_cnt),
		.pulse_cnt    (pulse_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// A hard stop in case the block hangs on a handshake.
	initial begin
		#TIMEOUT_NS;
		$display("FAIL");
		$finish;
	end

	// Receiver pacing. Each pass sets m_tready once and then lets at least one
	// clock go by, so the ready line never sees two updates in one time step.
	// A hold-off request from the stimulus holds ready low through a long hold-off,
	// while the sender keeps offering.
	initial begin
		int unsigned len;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end else if (!rx_eager && $urandom_range(0, 3) == 0) begin
				// Mostly short stalls, now and then a long one.
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
					$urandom_range(1, 3);
				m_tready <= 1'b0;
				repeat (len) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Gap after a transfer on the command side: usually none, sometimes a short
	// pause, rarely a long one. Eager phases never pause.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (tx_eager) begin
			return 0;
		end
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return 0;
		end
		if (r < 9) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Offer one command and hold it until the block takes it. The valid line
	// is only lowered when a gap follows, so back-to-back transfers keep it high.
	task automatic offer(input logic [ACTION_W-1:0] act, input logic cw,
			input logic [RATE_W-1:0] rate, input logic [COUNT_W-1:0] count);
		int unsigned gap;
		s_tuser  <= act;
		s_tdata  <= {{(IN_DATA_W - 1 - RATE_W - COUNT_W){1'b0}}, count, rate, cw};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		case (act)
			ACT_TICK: n_tick++;
			ACT_MOVE: n_move++;
			ACT_STOP: n_stop++;
			default:  n_unused++;
		endcase
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Register write, only called while no result is outstanding. The block
	// recomputes its hold length after a write and drops s_tready meanwhile,
	// so the next write waits until it is ready again.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_wdata <= data;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_writes++;
		if (idx == CFG_TICK_HZ) begin
			tick_setting = data[TICK_W-1:0];
		end
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stop offering and wait until every expected result has been checked,
	// then give the block time to come to rest.
	task automatic quiesce();
		int unsigned waited;
		waited = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_cnt != 0) begin
			$error("%0d results never arrived", pending_cnt);
			drain_stuck = 1'b1;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Step rates relative to the tick rate, so that pulses come every few
	// ticks whatever the tick rate is. Zero, full-range and exactly-the-tick-rate
	// values are mixed in.
	function automatic logic [RATE_W-1:0] pick_rate();
		logic [RATE_W-1:0] r;
		case ($urandom_range(0, 9))
			0: r = '0;
			1: r = $urandom;
			2: r = tick_setting;
			default: begin
				if (tick_setting == '0) begin
					r = $urandom_range(1, 50);
				end else begin
					r = tick_setting / $urandom_range(1, 5);
				end
				if (r == '0) begin
					r = 1;
				end
			end
		endcase
		return r;
	endfunction

	// Mostly short counted moves so that moves finish and holds run out;
	// some continuous moves and some with huge counts.
	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom;
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	// A fresh random setting for a phase. Every register is a candidate; the
	// written data carries random bits above each register's width.
	task automatic random_setting();
		logic [CFG_DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = '1;
			2: v = $urandom;
			default: v = $urandom_range(1, 40);
		endcase
		write_reg(CFG_TICK_HZ, v);
		if ($urandom_range(0, 2) != 0) begin
			v = $urandom;
			v[0] = ($urandom_range(0, 3) != 0);
			write_reg(CFG_HOLD_ON_STOP, v);
		end
		if ($urandom_range(0, 2) != 0) begin
			v = $urandom;
			case ($urandom_range(0, 5))
				0: v[HOLDMS_W-1:0] = '0;
				1: v[HOLDMS_W-1:0] = '1;
				default: v[HOLDMS_W-1:0] = $urandom_range(1, 400);
			endcase
			write_reg(CFG_HOLD_MS, v);
		end
		if ($urandom_range(0, 5) == 0) begin
			write_reg(CFG_NONE, $urandom);
		end
	endtask

	// One random command. Ticks dominate, since motion only advances on ticks;
	// ignored fields of ticks and stops still carry random bits.
	task automatic random_item(output bit counted);
		int unsigned r;
		r = $urandom_range(0, 99);
		counted = 1'b1;
		if (r < 70 || r >= 95) begin
			offer(ACT_TICK, $urandom_range(0, 1), $urandom, $urandom);
		end else if (r < 84) begin
			offer(ACT_MOVE, $urandom_range(0, 1), pick_rate(), pick_count());
		end else if (r < 92) begin
			offer(ACT_STOP, $urandom_range(0, 1), $urandom, $urandom);
		end else begin
			offer(ACT_UNUSED, $urandom_range(0, 1), $urandom, $urandom);
			counted = 1'b0;
		end
	endtask

	initial begin
		int unsigned done;
		bit counted;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_TICK_HZ;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= ACT_TICK;
		tick_setting = '0;
		tx_eager     = 1'b0;
		rx_eager     = 1'b0;
		holdoff_req  = 1'b0;
		drain_stuck  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the tick rate is zero and the hold is endless: a tick
		// does nothing, a move acts as a stop that keeps the driver enabled,
		// and the unused action code changes nothing.
		offer(ACT_TICK, 1'b1, '0, '0);
		offer(ACT_MOVE, 1'b0, 32'd5, 32'd3);
		offer(ACT_UNUSED, 1'b1, '1, '1);
		quiesce();

		// Four ticks per second with a 500 ms hold gives a two-tick hold.
		// Upper data bits are set to show that they are dropped, and a write
		// to a register that does not exist must change nothing.
		write_reg(CFG_TICK_HZ, 32'd4);
		write_reg(CFG_HOLD_ON_STOP, '1);
		write_reg(CFG_HOLD_MS, {16'hA5A5, 16'd500});
		write_reg(CFG_NONE, 32'h1234_5678);

		// A rate above the tick rate is clamped, so every non-pulse tick steps.
		// After the second pulse the block stops itself and the hold runs out.
		offer(ACT_MOVE, 1'b0, '1, 32'd2);
		repeat (6) offer(ACT_TICK, 1'b0, '0, '0);
		// Zero rate acts as a stop; the following move cancels the hold it started.
		offer(ACT_MOVE, 1'b1, '0, 32'd7);
		offer(ACT_MOVE, 1'b1, 32'd1, '0);
		repeat (4) offer(ACT_TICK, 1'b1, '1, '1);
		offer(ACT_STOP, 1'b0, '0, '0);
		// A stop while idle restarts the hold.
		offer(ACT_STOP, 1'b1, '1, '1);
		quiesce();

		// Without hold the driver is released as soon as the move ends.
		write_reg(CFG_HOLD_ON_STOP, '0);
		offer(ACT_MOVE, 1'b1, 32'd3, 32'd1);
		repeat (3) offer(ACT_TICK, 1'b0, '0, '0);
		quiesce();

		// Largest tick rate and hold time.
		write_reg(CFG_TICK_HZ, '1);
		write_reg(CFG_HOLD_ON_STOP, 32'd1);
		write_reg(CFG_HOLD_MS, 32'h0000_FFFF);
		offer(ACT_MOVE, 1'b0, 32'hFFFF_FFFE, '0);
		offer(ACT_TICK, 1'b0, '0, '0);
		quiesce();

		// The tick rate drops to zero while the motor runs: every non-pulse tick
		// now steps, and a stop with a zero tick rate releases the driver.
		write_reg(CFG_TICK_HZ, '0);
		repeat (2) offer(ACT_TICK, 1'b1, '0, '0);
		offer(ACT_STOP, 1'b0, '0, '0);
		quiesce();

		// The longest hold saturates the tick counter.
		write_reg(CFG_TICK_HZ, '1);
		offer(ACT_STOP, 1'b0, '0, '0);
		quiesce();

		// Random phases, each under its own setting. Phase 2 starts with a long
		// receiver hold-off that backs the block up; phase 3 pauses the sender
		// halfway until all results are in. Some phases run without gaps.
		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			random_setting();
			tx_eager = (p == 1 || p == 4);
			rx_eager = (p == 1 || p == 5);
			if (p == 2) begin
				holdoff_req = 1'b1;
			end
			done = 0;
			while (done < ITEMS_PER_PHASE) begin
				random_item(counted);
				if (counted) begin
					done++;
				end
				if (p == 3 && done == ITEMS_PER_PHASE / 2 && counted) begin
					quiesce();
				end
			end
			quiesce();
		end

		$display("Sent %0d ticks, %0d moves, %0d stops and %0d unused codes; %0d register writes.",
			n_tick, n_move, n_stop, n_unused, n_writes);
		$display("Compared %0d results, %0d of them with the step output high.",
			checked_cnt, pulse_cnt);
		if (mismatch_cnt == 0 && pending_cnt == 0 && !drain_stuck) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/spg_pkg.sv
rtl/stepper_pulse_generator_unit.sv
bench/spg_levels_check.sv
bench/tb.sv
